// ----- rtl/prp_pkg.sv -----
// ----------------------------------------------------------------------------
// prp_pkg
// Shared types, constants and width helpers for the point rotate/project block.
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int COORD_W         = 16;
  localparam int TRIG_W          = 16;
  localparam int CENTER_W        = 16;
  localparam int SCREEN_W        = 16;
  localparam int CAMERA_DISTANCE = 20;
  localparam int FOCAL_LENGTH    = 100;
  localparam int FOCAL_W         = 8;
  localparam int SCREEN_MAX      = 32767;
  localparam int SCREEN_MIN      = -32768;
  localparam int REG_INDEX_W     = 3;
  localparam int QUEUE_DEPTH     = 4;

  // Register map of the configuration port
  typedef enum logic [REG_INDEX_W-1:0] {
    REG_COS_X    = 3'd0,
    REG_SIN_X    = 3'd1,
    REG_COS_Y    = 3'd2,
    REG_SIN_Y    = 3'd3,
    REG_COS_Z    = 3'd4,
    REG_SIN_Z    = 3'd5,
    REG_CENTER_X = 3'd6,
    REG_CENTER_Y = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0]   cos_x;
    logic signed [TRIG_W-1:0]   sin_x;
    logic signed [TRIG_W-1:0]   cos_y;
    logic signed [TRIG_W-1:0]   sin_y;
    logic signed [TRIG_W-1:0]   cos_z;
    logic signed [TRIG_W-1:0]   sin_z;
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
  } cfg_regs_t;

  // Width of a coordinate after one rotation pass
  function automatic int rot_w(input int w, input int t);
    return w + TRIG_W + 1 - t;
  endfunction

  // Width of a fully rotated coordinate
  function automatic int coord_w(input int t);
    return rot_w(rot_w(rot_w(COORD_W, t), t), t);
  endfunction

  // Width of the depth z + camera distance
  function automatic int depth_w(input int p, input int t);
    int c;
    c = coord_w(t);
    return ((c > p + 6) ? c : p + 6) + 1;
  endfunction

  // Width of the projection numerator
  function automatic int num_w(input int p, input int t);
    int a;
    int b;
    a = coord_w(t) + FOCAL_W;
    b = CENTER_W + depth_w(p, t);
    return ((a > b) ? a : b) + 1;
  endfunction

endpackage

// ----- rtl/prp_point_if.sv -----
// ----------------------------------------------------------------------------
// prp_point_if
// Input point channel: valid/ready with one 3-D point per beat.
// ----------------------------------------------------------------------------
interface prp_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [prp_pkg::COORD_W-1:0]  point_x;
  logic signed [prp_pkg::COORD_W-1:0]  point_y;
  logic signed [prp_pkg::COORD_W-1:0]  point_z;
  logic                                point_active;

  modport source (output valid, point_x, point_y, point_z, point_active, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_active, output ready);
endinterface

// ----- rtl/prp_screen_if.sv -----
// ----------------------------------------------------------------------------
// prp_screen_if
// Output pixel channel: valid/ready with one screen position per beat.
// ----------------------------------------------------------------------------
interface prp_screen_if;
  logic                                valid;
  logic                                ready;
  logic signed [prp_pkg::SCREEN_W-1:0] screen_x;
  logic signed [prp_pkg::SCREEN_W-1:0] screen_y;
  logic                                plot;

  modport source (output valid, screen_x, screen_y, plot, input ready);
  modport sink   (input valid, screen_x, screen_y, plot, output ready);
endinterface

// ----- rtl/prp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// prp_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
interface prp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [prp_pkg::REG_INDEX_W-1:0]     index;
  logic [prp_pkg::TRIG_W-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/prp_front.sv -----
// ----------------------------------------------------------------------------
// prp_front
// Rotation pipeline: about X, Y, Z (multiply stage then sum/shift stage each),
// ends with the depth and the plot decision.
// ----------------------------------------------------------------------------
module prp_front #(
  parameter int POSITION_FRACTION_BITS = 8,
  parameter int TRIG_FRACTION_BITS     = 14
) (
  input  logic                clk,
  input  logic                rst,
  prp_point_if.sink           point,
  input  prp_pkg::cfg_regs_t  regs,
  input  logic                q_full,
  output logic                push,
  output logic [prp_pkg::coord_w(TRIG_FRACTION_BITS)-1:0] x_out,
  output logic [prp_pkg::coord_w(TRIG_FRACTION_BITS)-1:0] y_out,
  output logic [prp_pkg::depth_w(POSITION_FRACTION_BITS, TRIG_FRACTION_BITS)-1:0] d_out,
  output logic                plot_out
);

  localparam int T  = TRIG_FRACTION_BITS;
  localparam int TW = prp_pkg::TRIG_W;
  localparam int W0 = prp_pkg::COORD_W;
  localparam int W1 = prp_pkg::rot_w(W0, T);
  localparam int W2 = prp_pkg::rot_w(W1, T);
  localparam int W3 = prp_pkg::rot_w(W2, T);
  localparam int DW = prp_pkg::depth_w(POSITION_FRACTION_BITS, T);
  localparam logic signed [DW-1:0] DEPTH_BIAS =
    DW'(prp_pkg::CAMERA_DISTANCE) << POSITION_FRACTION_BITS;

  logic [5:0] vld;
  logic       adv;
  logic       act [5];

  // stage 0/1: about X
  logic signed [W0+TW-1:0] a1_p0, a1_p1, a1_p2, a1_p3;
  logic signed [W0-1:0]    a1_x;
  logic signed [W1-1:0]    b1_x, b1_y, b1_z;
  logic signed [W0+TW:0]   s1_y, s1_z;
  // stage 2/3: about Y
  logic signed [W1+TW-1:0] a2_p0, a2_p1, a2_p2, a2_p3;
  logic signed [W1-1:0]    a2_y;
  logic signed [W2-1:0]    b2_x, b2_y, b2_z;
  logic signed [W1+TW:0]   s2_z, s2_x;
  // stage 4/5: about Z
  logic signed [W2+TW-1:0] a3_p0, a3_p1, a3_p2, a3_p3;
  logic signed [W2-1:0]    a3_z;
  logic signed [W2+TW:0]   s3_x, s3_y;
  logic signed [W3-1:0]    z3;
  logic signed [DW-1:0]    depth;

  // Stall the whole front only when the last stage cannot drain
  assign adv         = !(vld[5] && q_full);
  assign point.ready = adv;
  assign push        = vld[5] && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[4:0], point.valid};
    end
  end

  // Rotation sums, exact width, then floor shift
  always_comb begin
    s1_y  = (W0+TW+1)'(a1_p0) - (W0+TW+1)'(a1_p1);
    s1_z  = (W0+TW+1)'(a1_p2) + (W0+TW+1)'(a1_p3);
    s2_z  = (W1+TW+1)'(a2_p0) - (W1+TW+1)'(a2_p1);
    s2_x  = (W1+TW+1)'(a2_p2) + (W1+TW+1)'(a2_p3);
    s3_x  = (W2+TW+1)'(a3_p0) - (W2+TW+1)'(a3_p1);
    s3_y  = (W2+TW+1)'(a3_p2) + (W2+TW+1)'(a3_p3);
    z3    = W3'(a3_z);
    depth = DW'(z3) + DEPTH_BIAS;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // about X: products
      a1_p0  <= point.point_y * regs.cos_x;
      a1_p1  <= point.point_z * regs.sin_x;
      a1_p2  <= point.point_z * regs.cos_x;
      a1_p3  <= point.point_y * regs.sin_x;
      a1_x   <= point.point_x;
      act[0] <= point.point_active;
      // about X: sums
      b1_x   <= W1'(a1_x);
      b1_y   <= W1'(s1_y >>> T);
      b1_z   <= W1'(s1_z >>> T);
      act[1] <= act[0];
      // about Y: products
      a2_p0  <= b1_z * regs.cos_y;
      a2_p1  <= b1_x * regs.sin_y;
      a2_p2  <= b1_x * regs.cos_y;
      a2_p3  <= b1_z * regs.sin_y;
      a2_y   <= b1_y;
      act[2] <= act[1];
      // about Y: sums
      b2_z   <= W2'(s2_z >>> T);
      b2_x   <= W2'(s2_x >>> T);
      b2_y   <= W2'(a2_y);
      act[3] <= act[2];
      // about Z: products
      a3_p0  <= b2_x * regs.cos_z;
      a3_p1  <= b2_y * regs.sin_z;
      a3_p2  <= b2_y * regs.cos_z;
      a3_p3  <= b2_x * regs.sin_z;
      a3_z   <= b2_z;
      act[4] <= act[3];
      // about Z: sums, depth and plot decision
      x_out    <= W3'(s3_x >>> T);
      y_out    <= W3'(s3_y >>> T);
      d_out    <= depth;
      plot_out <= act[4] && (depth != '0);
    end
  end

endmodule

// ----- rtl/prp_queue.sv -----
// ----------------------------------------------------------------------------
// prp_queue
// Small register FIFO decoupling the rotation front from the projection back.
// ----------------------------------------------------------------------------
module prp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/prp_back.sv -----
// ----------------------------------------------------------------------------
// prp_back
// Projection pipeline: numerators, magnitudes, one-bit-per-stage restoring
// divider for x and y, then sign, saturation and the output register.
// ----------------------------------------------------------------------------
module prp_back #(
  parameter int POSITION_FRACTION_BITS = 8,
  parameter int TRIG_FRACTION_BITS     = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  prp_pkg::cfg_regs_t  regs,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic [prp_pkg::coord_w(TRIG_FRACTION_BITS)-1:0] x_in,
  input  logic [prp_pkg::coord_w(TRIG_FRACTION_BITS)-1:0] y_in,
  input  logic [prp_pkg::depth_w(POSITION_FRACTION_BITS, TRIG_FRACTION_BITS)-1:0] d_in,
  input  logic                plot_in,
  prp_screen_if.source        pixel
);

  localparam int XW = prp_pkg::coord_w(TRIG_FRACTION_BITS);
  localparam int DW = prp_pkg::depth_w(POSITION_FRACTION_BITS, TRIG_FRACTION_BITS);
  localparam int NW = prp_pkg::num_w(POSITION_FRACTION_BITS, TRIG_FRACTION_BITS);
  localparam int FW = prp_pkg::FOCAL_W;
  localparam int CW = prp_pkg::CENTER_W;
  localparam int SW = prp_pkg::SCREEN_W;
  localparam logic signed [FW-1:0] FOCAL = FW'(prp_pkg::FOCAL_LENGTH);

  logic badv;

  // numerator products
  logic                  c0_v, c0_plot;
  logic signed [XW+FW-1:0] c0_fx, c0_fy;
  logic signed [CW+DW-1:0] c0_cx, c0_cy;
  logic signed [DW-1:0]    c0_d;
  // numerator sums
  logic                  c1_v, c1_plot;
  logic signed [NW-1:0]  c1_nx, c1_ny;
  logic signed [DW-1:0]  c1_d;

  // divider stages; index 0 holds the magnitudes
  logic [NW:0]    vld;
  logic [DW-1:0]  rem_x [NW+1];
  logic [DW-1:0]  rem_y [NW+1];
  logic [NW-1:0]  qx_sh [NW+1];
  logic [NW-1:0]  qy_sh [NW+1];
  logic [DW-1:0]  dv    [NW+1];
  logic           neg_x [NW+1];
  logic           neg_y [NW+1];
  logic           pl    [NW+1];

  logic signed [NW:0]   qs_x, qs_y;
  logic signed [SW-1:0] sat_x, sat_y;

  // Whole back pipeline moves when the output register can take a beat
  assign badv  = !pixel.valid || pixel.ready;
  assign q_pop = q_valid && badv;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0_v <= 1'b0;
      c1_v <= 1'b0;
      vld  <= '0;
    end else if (badv) begin
      c0_v <= q_valid;
      c1_v <= c0_v;
      vld  <= {vld[NW-1:0], c1_v};
    end
  end

  // Products, sums and magnitudes
  always_ff @(posedge clk) begin
    if (badv) begin
      c0_fx   <= $signed(x_in) * FOCAL;
      c0_fy   <= $signed(y_in) * FOCAL;
      c0_cx   <= regs.center_x * $signed(d_in);
      c0_cy   <= regs.center_y * $signed(d_in);
      c0_d    <= d_in;
      c0_plot <= plot_in;

      c1_nx   <= NW'(c0_cx) + NW'(c0_fx);
      c1_ny   <= NW'(c0_cy) - NW'(c0_fy);
      c1_d    <= c0_d;
      c1_plot <= c0_plot;

      rem_x[0] <= '0;
      rem_y[0] <= '0;
      qx_sh[0] <= c1_nx[NW-1] ? NW'(-c1_nx) : c1_nx;
      qy_sh[0] <= c1_ny[NW-1] ? NW'(-c1_ny) : c1_ny;
      // a zero divisor only occurs for non-plotted beats
      dv[0]    <= c1_plot ? (c1_d[DW-1] ? DW'(-c1_d) : c1_d) : DW'(1);
      neg_x[0] <= c1_nx[NW-1] ^ c1_d[DW-1];
      neg_y[0] <= c1_ny[NW-1] ^ c1_d[DW-1];
      pl[0]    <= c1_plot;
    end
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= NW; k++) begin : g_div
    logic [DW:0] tx, ty;
    logic        gx, gy;

    always_comb begin
      tx = {rem_x[k-1], qx_sh[k-1][NW-1]};
      ty = {rem_y[k-1], qy_sh[k-1][NW-1]};
      gx = (tx >= {1'b0, dv[k-1]});
      gy = (ty >= {1'b0, dv[k-1]});
    end

    always_ff @(posedge clk) begin
      if (badv) begin
        rem_x[k] <= gx ? DW'(tx - {1'b0, dv[k-1]}) : tx[DW-1:0];
        rem_y[k] <= gy ? DW'(ty - {1'b0, dv[k-1]}) : ty[DW-1:0];
        qx_sh[k] <= {qx_sh[k-1][NW-2:0], gx};
        qy_sh[k] <= {qy_sh[k-1][NW-2:0], gy};
        dv[k]    <= dv[k-1];
        neg_x[k] <= neg_x[k-1];
        neg_y[k] <= neg_y[k-1];
        pl[k]    <= pl[k-1];
      end
    end
  end

  // Apply sign and saturate
  always_comb begin
    qs_x = neg_x[NW] ? -$signed({1'b0, qx_sh[NW]}) : $signed({1'b0, qx_sh[NW]});
    qs_y = neg_y[NW] ? -$signed({1'b0, qy_sh[NW]}) : $signed({1'b0, qy_sh[NW]});
    if (qs_x > (NW+1)'(prp_pkg::SCREEN_MAX)) begin
      sat_x = SW'(prp_pkg::SCREEN_MAX);
    end else if (qs_x < (NW+1)'(prp_pkg::SCREEN_MIN)) begin
      sat_x = SW'(prp_pkg::SCREEN_MIN);
    end else begin
      sat_x = SW'(qs_x);
    end
    if (qs_y > (NW+1)'(prp_pkg::SCREEN_MAX)) begin
      sat_y = SW'(prp_pkg::SCREEN_MAX);
    end else if (qs_y < (NW+1)'(prp_pkg::SCREEN_MIN)) begin
      sat_y = SW'(prp_pkg::SCREEN_MIN);
    end else begin
      sat_y = SW'(qs_y);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (badv) begin
      pixel.valid <= vld[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (badv) begin
      pixel.screen_x <= pl[NW] ? sat_x : '0;
      pixel.screen_y <= pl[NW] ? sat_y : '0;
      pixel.plot     <= pl[NW];
    end
  end

endmodule

// ----- rtl/point_rotate_project.sv -----
// ----------------------------------------------------------------------------
// point_rotate_project
// Rotates a 3-D point about X, Y and Z and projects it onto the screen.
// ----------------------------------------------------------------------------
// Channels: "point" takes one point per beat (Q8.8 x, y, z and an active
// flag); "pixel" returns exactly one beat per point, in order, with the
// saturated screen position and a plot flag; "cfg" writes the eight
// rotation/center registers and is always ready.
// Throughput: one point per cycle, sustained while the receiver is ready.
// Pipeline at the default parameters: 6 rotation stages, one queue
// slot, 3 numerator stages, one divider stage per numerator bit (43) and the
// output register. The bit-serial divider pipeline is the longest part.
// Reset clears all valid bits and the queue and loads the register defaults.
// When the receiver stalls the projection pipeline holds; the rotation
// pipeline keeps filling the 4-entry queue and holds once it is full,
// dropping point.ready.
// ----------------------------------------------------------------------------
module point_rotate_project #(
  parameter int POSITION_FRACTION_BITS = 8,
  parameter int TRIG_FRACTION_BITS     = 14
) (
  input  logic          clk,
  input  logic          rst,
  prp_point_if.sink     point,
  prp_screen_if.source  pixel,
  prp_cfg_if.sink       cfg
);

  localparam int XW = prp_pkg::coord_w(TRIG_FRACTION_BITS);
  localparam int DW = prp_pkg::depth_w(POSITION_FRACTION_BITS, TRIG_FRACTION_BITS);
  localparam int QW = 2 * XW + DW + 1;

  prp_pkg::cfg_regs_t regs;

  logic          push, pop, q_full, q_valid;
  logic [XW-1:0] fx, fy, bx, by;
  logic [DW-1:0] fd, bd;
  logic          fplot, bplot;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.cos_x    <= -16'sd4520;
      regs.sin_x    <= -16'sd15744;
      regs.cos_y    <= 16'sd16384;
      regs.sin_y    <= 16'sd0;
      regs.cos_z    <= 16'sd16384;
      regs.sin_z    <= 16'sd0;
      regs.center_x <= 16'sd80;
      regs.center_y <= 16'sd29;
    end else if (cfg.valid) begin
      unique case (prp_pkg::reg_index_t'(cfg.index))
        prp_pkg::REG_COS_X:    regs.cos_x    <= cfg.data;
        prp_pkg::REG_SIN_X:    regs.sin_x    <= cfg.data;
        prp_pkg::REG_COS_Y:    regs.cos_y    <= cfg.data;
        prp_pkg::REG_SIN_Y:    regs.sin_y    <= cfg.data;
        prp_pkg::REG_COS_Z:    regs.cos_z    <= cfg.data;
        prp_pkg::REG_SIN_Z:    regs.sin_z    <= cfg.data;
        prp_pkg::REG_CENTER_X: regs.center_x <= cfg.data;
        prp_pkg::REG_CENTER_Y: regs.center_y <= cfg.data;
        default: ;
      endcase
    end
  end

  prp_front #(
    .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS),
    .TRIG_FRACTION_BITS     (TRIG_FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .point    (point),
    .regs     (regs),
    .q_full   (q_full),
    .push     (push),
    .x_out    (fx),
    .y_out    (fy),
    .d_out    (fd),
    .plot_out (fplot)
  );

  prp_queue #(
    .WIDTH (QW),
    .DEPTH (prp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({fplot, fd, fy, fx}),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .pop_data  ({bplot, bd, by, bx})
  );

  prp_back #(
    .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS),
    .TRIG_FRACTION_BITS     (TRIG_FRACTION_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .q_valid (q_valid),
    .q_pop   (pop),
    .x_in    (bx),
    .y_in    (by),
    .d_in    (bd),
    .plot_in (bplot),
    .pixel   (pixel)
  );

endmodule

// ----- rtl/prp_checker.sv -----
// ----------------------------------------------------------------------------
// prp_checker
// Port-level checks on the pixel channel, bound to the top level.
// ----------------------------------------------------------------------------
module prp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                pixel_valid,
  input logic                                pixel_ready,
  input logic signed [prp_pkg::SCREEN_W-1:0] screen_x,
  input logic signed [prp_pkg::SCREEN_W-1:0] screen_y,
  input logic                                plot
);

  // A stalled beat stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=> pixel_valid)
    else $error("pixel beat dropped while stalled");

  // A stalled beat keeps its payload
  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=> ($stable(screen_x) && $stable(screen_y) && $stable(plot)))
    else $error("pixel payload changed while stalled");

  // Unplotted beats carry a zero position
  a_zero_unplotted: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !plot) |-> (screen_x == '0 && screen_y == '0))
    else $error("unplotted pixel with nonzero position");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel beat offered after reset");

endmodule

bind point_rotate_project prp_checker u_prp_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel.valid),
  .pixel_ready (pixel.ready),
  .screen_x    (pixel.screen_x),
  .screen_y    (pixel.screen_y),
  .plot        (pixel.plot)
);
